/* hdl/stable_sorted_priority_queue_unit_macros.svh */
// Assertion helpers used by the queue controller.
`ifndef STABLE_SORTED_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define STABLE_SORTED_PRIORITY_QUEUE_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define SSQ_ASSERT_SAME(label, clk, rst_n, cond, conseq) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
    else $error("queue assertion failed");
`define SSQ_ASSERT_NEXT(label, clk, rst_n, cond, conseq) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
    else $error("queue assertion failed");
`else
`define SSQ_ASSERT_SAME(label, clk, rst_n, cond, conseq)
`define SSQ_ASSERT_NEXT(label, clk, rst_n, cond, conseq)
`endif

`endif

/* hdl/ssq_pkg.sv */
`timescale 1ns / 1ps

package ssq_pkg;

  localparam int KEY_WIDTH      = 4;
  localparam int OUT_TAG_WIDTH  = 16;
  localparam int OUT_CNT_WIDTH  = 5;

  localparam logic [1:0] ACT_PUSH  = 2'd0;
  localparam logic [1:0] ACT_POP   = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

endpackage

/* hdl/ssq_ctrl.sv */
`timescale 1ns / 1ps
`include "stable_sorted_priority_queue_unit_macros.svh"

module ssq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  output ssq_pkg::cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   fire;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign fire       = (state_r == S_EXEC) && (!out_valid_r || out_tready);
  assign cmd.load   = in_tvalid && in_tready;
  assign cmd.exec   = fire;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (fire) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `SSQ_ASSERT_NEXT(a_accept_to_exec, clk, rst_n, cmd.load, state_r == S_EXEC)
  `SSQ_ASSERT_NEXT(a_fire_gives_beat, clk, rst_n, fire, out_valid_r && state_r == S_IDLE)
  `SSQ_ASSERT_NEXT(a_stall_holds, clk, rst_n,
                   state_r == S_EXEC && out_valid_r && !out_tready,
                   state_r == S_EXEC && out_valid_r)
  `SSQ_ASSERT_SAME(a_no_load_in_exec, clk, rst_n, state_r == S_EXEC, !cmd.load)

endmodule

/* hdl/ssq_datapath.sv */
`timescale 1ns / 1ps

module ssq_datapath #(
  parameter int DEPTH     = 16,
  parameter int TAG_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ssq_pkg::cmd_t                       cmd,
  input  logic [1:0]                          in_action,
  input  logic [ssq_pkg::KEY_WIDTH-1:0]       in_priority_key,
  input  logic [ssq_pkg::OUT_TAG_WIDTH-1:0]   in_payload_tag,
  output logic                                out_popped_valid,
  output logic [ssq_pkg::KEY_WIDTH-1:0]       out_popped_key,
  output logic [ssq_pkg::OUT_TAG_WIDTH-1:0]   out_popped_tag,
  output logic [1:0]                          out_status,
  output logic [ssq_pkg::OUT_CNT_WIDTH-1:0]   out_entry_count
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  logic [1:0]                    act_r;
  logic [ssq_pkg::KEY_WIDTH-1:0] ckey_r;
  logic [TAG_WIDTH-1:0]          ctag_r;

  logic [ssq_pkg::KEY_WIDTH-1:0] ekey_r   [DEPTH];
  logic [ssq_pkg::KEY_WIDTH-1:0] ekey_nxt [DEPTH];
  logic [TAG_WIDTH-1:0]          etag_r   [DEPTH];
  logic [TAG_WIDTH-1:0]          etag_nxt [DEPTH];
  logic [CW-1:0]                 count_r, count_nxt;
  logic [DEPTH-1:0]              ge;

  logic                                res_valid_r, res_valid_nxt;
  logic [ssq_pkg::KEY_WIDTH-1:0]       res_key_r, res_key_nxt;
  logic [ssq_pkg::OUT_TAG_WIDTH-1:0]   res_tag_r, res_tag_nxt;
  logic [1:0]                          res_status_r, res_status_nxt;
  logic [ssq_pkg::OUT_CNT_WIDTH-1:0]   res_count_r;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ge[i] = (CW'(i) < count_r) && (ekey_r[i] >= ckey_r);
    end
  end

  always_comb begin
    logic                          prev_ge;
    logic [ssq_pkg::KEY_WIDTH-1:0] prev_key;
    logic [TAG_WIDTH-1:0]          prev_tag;
    prev_ge        = 1'b1;
    prev_key       = ckey_r;
    prev_tag       = ctag_r;
    count_nxt      = count_r;
    res_valid_nxt  = 1'b0;
    res_key_nxt    = '0;
    res_tag_nxt    = '0;
    res_status_nxt = ssq_pkg::ST_OK;
    for (int i = 0; i < DEPTH; i++) begin
      ekey_nxt[i] = ekey_r[i];
      etag_nxt[i] = etag_r[i];
    end
    unique case (act_r)
      ssq_pkg::ACT_PUSH: begin
        if (count_r == FULL_COUNT) begin
          res_status_nxt = ssq_pkg::ST_FULL;
        end else begin
          for (int i = 0; i < DEPTH; i++) begin
            if (!ge[i]) begin
              if (prev_ge) begin
                ekey_nxt[i] = ckey_r;
                etag_nxt[i] = ctag_r;
              end else begin
                ekey_nxt[i] = prev_key;
                etag_nxt[i] = prev_tag;
              end
            end
            prev_ge  = ge[i];
            prev_key = ekey_r[i];
            prev_tag = etag_r[i];
          end
          count_nxt = count_r + CW'(1);
        end
      end
      ssq_pkg::ACT_POP: begin
        if (count_r == '0) begin
          res_status_nxt = ssq_pkg::ST_EMPTY;
        end else begin
          res_valid_nxt = 1'b1;
          res_key_nxt   = ekey_r[0];
          res_tag_nxt   = ssq_pkg::OUT_TAG_WIDTH'(64'(etag_r[0]));
          for (int i = 0; i < DEPTH - 1; i++) begin
            ekey_nxt[i] = ekey_r[i + 1];
            etag_nxt[i] = etag_r[i + 1];
          end
          count_nxt = count_r - CW'(1);
        end
      end
      ssq_pkg::ACT_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r  <= in_action;
      ckey_r <= in_priority_key;
      ctag_r <= TAG_WIDTH'(64'(in_payload_tag));
    end
    if (cmd.exec) begin
      for (int i = 0; i < DEPTH; i++) begin
        ekey_r[i] <= ekey_nxt[i];
        etag_r[i] <= etag_nxt[i];
      end
      res_valid_r  <= res_valid_nxt;
      res_key_r    <= res_key_nxt;
      res_tag_r    <= res_tag_nxt;
      res_status_r <= res_status_nxt;
      res_count_r  <= ssq_pkg::OUT_CNT_WIDTH'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.exec) begin
      count_r <= count_nxt;
    end
  end

  assign out_popped_valid = res_valid_r;
  assign out_popped_key   = res_key_r;
  assign out_popped_tag   = res_tag_r;
  assign out_status       = res_status_r;
  assign out_entry_count  = res_count_r;

endmodule

/* hdl/stable_sorted_priority_queue_unit.sv */
// An accepted beat is loaded into the command registers; its result is registered when
// the controller's execute state fires, and no new beat is accepted before then; an
// unaccepted result holds the next beat in execute, which blocks the input.
// The sorted entry shift register updates all slots in parallel in the execute cycle.
// Reset (rst_n, synchronous, active low) empties the queue and drops any pending beat.
`timescale 1ns / 1ps

module stable_sorted_priority_queue_unit #(
  parameter int DEPTH     = 16,
  parameter int TAG_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // priority_key [3:0], payload_tag [19:4], zero [23:20]
  input  logic [1:0]  in_tuser,   // action [1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // popped_valid [0], popped_key [4:1], popped_tag [20:5],
                                  // entry_count [25:21], zero [31:26]
  output logic [1:0]  out_tuser   // status [1:0]
);

  ssq_pkg::cmd_t cmd;

  logic                              popped_valid;
  logic [ssq_pkg::KEY_WIDTH-1:0]     popped_key;
  logic [ssq_pkg::OUT_TAG_WIDTH-1:0] popped_tag;
  logic [ssq_pkg::OUT_CNT_WIDTH-1:0] entry_count;

  ssq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  ssq_datapath #(
    .DEPTH     (DEPTH),
    .TAG_WIDTH (TAG_WIDTH)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_action        (in_tuser),
    .in_priority_key  (in_tdata[3:0]),
    .in_payload_tag   (in_tdata[19:4]),
    .out_popped_valid (popped_valid),
    .out_popped_key   (popped_key),
    .out_popped_tag   (popped_tag),
    .out_status       (out_tuser),
    .out_entry_count  (entry_count)
  );

  assign out_tdata = {6'd0, entry_count, popped_tag, popped_key, popped_valid};

endmodule
